// ===== src/dlle_pkg.sv =====
package dlle_pkg;

  localparam int MAX_LABEL_DEF = 63;
  localparam int CNT_W = 6;
  localparam logic [7:0] SEP_RESET = 8'd46;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_length;
    logic       last_of_run;
    logic       name_end;
    logic       overflow;
  } out_item_t;

  // One finished label, handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             name_end;
    logic             bank;
  } label_cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEN,
    B_READ,
    B_DATA
  } back_state_t;

endpackage

// ===== src/dns_label_length_encoder.sv =====
// DNS label length encoder.
// Input channel (in_valid/in_ready, in_item): one item per transfer, either a
// name byte or an end-of-name marker. A byte equal to the separator register
// (cfg_we/cfg_wdata, dot after reset) or an end-of-name item closes the
// current label. Output channel (out_valid/out_ready, out_item): the label's
// length byte, then its stored bytes; name_end flags the final result of a
// name, and no zero terminator is sent.
// Name bytes are taken one per cycle while in_ready is high and give no result.
// A closing item queues a label command; once the back end is idle it takes
// the command and loads the length byte into the output register. Each data
// byte then goes through a label store read and an output register load, and
// the next byte is not read until the previous one is loaded. The store holds
// two labels, so input keeps flowing while the previous label drains; with two
// closed labels pending, in_ready drops until one is fully sent.
// A stalled receiver holds the output register and the back end; the front
// still fills the free label bank. Reset clears counts and queue state and
// sets the separator to a dot; the label store is not cleared.
module dns_label_length_encoder #(
  parameter int MAX_LABEL = dlle_pkg::MAX_LABEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlle_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dlle_pkg::out_item_t out_item
);

  localparam int DEPTH = 2 * MAX_LABEL;
  localparam int AW = $clog2(DEPTH);

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [7:0]           rd_data;
  logic                 push;
  dlle_pkg::label_cmd_t push_cmd;
  logic                 pop;
  dlle_pkg::label_cmd_t pop_cmd;
  logic [1:0]           fill;
  logic                 busy;

  // Each closed label holds one bank until fully sent; two banks in all.
  assign in_ready = (fill + {1'b0, busy}) < 2'd2;

  dlle_front #(.MAX_LABEL(MAX_LABEL), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .allow     (in_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dlle_label_buf #(.DEPTH(DEPTH), .AW(AW)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dlle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .fill     (fill)
  );

  dlle_back #(.MAX_LABEL(MAX_LABEL), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (fill != 2'd0),
    .cmd_in    (pop_cmd),
    .pop       (pop),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== src/dlle_label_buf.sv =====
module dlle_label_buf #(
  parameter int DEPTH = 2 * dlle_pkg::MAX_LABEL_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dlle_front.sv =====
module dlle_front #(
  parameter int MAX_LABEL = dlle_pkg::MAX_LABEL_DEF,
  parameter int AW = $clog2(2 * MAX_LABEL)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  input  dlle_pkg::in_item_t   in_item,
  input  logic                 allow,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic                 push,
  output dlle_pkg::label_cmd_t push_cmd
);

  logic [7:0]                 sep_r;
  logic [dlle_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       bank_r, bank_nxt;
  logic                       accept;
  logic                       is_flush;
  logic                       room;

  assign accept   = in_valid && allow;
  assign is_flush = in_item.kind || (in_item.in_byte == sep_r);
  assign room     = count_r < dlle_pkg::CNT_W'(MAX_LABEL);

  assign wr_en   = accept && !is_flush && room;
  assign wr_addr = AW'(count_r) + (bank_r ? AW'(MAX_LABEL) : AW'(0));
  assign wr_data = in_item.in_byte;

  assign push              = accept && is_flush;
  assign push_cmd.count    = count_r;
  assign push_cmd.ovf      = ovf_r;
  assign push_cmd.name_end = in_item.kind;
  assign push_cmd.bank     = bank_r;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    if (push) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      bank_nxt  = !bank_r;
    end else if (accept) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= dlle_pkg::SEP_RESET;
      count_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

// ===== src/dlle_cmd_fifo.sv =====
module dlle_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dlle_pkg::label_cmd_t push_cmd,
  input  logic                 pop,
  output dlle_pkg::label_cmd_t pop_cmd,
  output logic [1:0]           fill
);

  dlle_pkg::label_cmd_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r, fill_nxt;

  assign pop_cmd = entry_r[rd_ptr_r];
  assign fill    = fill_r;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== src/dlle_back.sv =====
module dlle_back #(
  parameter int MAX_LABEL = dlle_pkg::MAX_LABEL_DEF,
  parameter int AW = $clog2(2 * MAX_LABEL)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_avail,
  input  dlle_pkg::label_cmd_t cmd_in,
  output logic                 pop,
  output logic                 busy,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dlle_pkg::out_item_t  out_item
);

  dlle_pkg::back_state_t      state_r, state_nxt;
  dlle_pkg::label_cmd_t       cmd_r;
  logic [dlle_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  dlle_pkg::out_item_t        out_item_r, out_item_nxt;
  logic                       slot_free;
  logic                       load;
  logic                       data_last;

  assign slot_free = !out_valid_r || out_ready;
  assign data_last = (idx_r + 1'b1) == cmd_r.count;
  assign busy      = state_r != dlle_pkg::B_IDLE;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlle_pkg::B_IDLE: begin
        if (cmd_avail) begin
          state_nxt = dlle_pkg::B_LEN;
        end
      end
      dlle_pkg::B_LEN: begin
        if (slot_free) begin
          state_nxt = (cmd_r.count == '0) ? dlle_pkg::B_IDLE : dlle_pkg::B_READ;
        end
      end
      dlle_pkg::B_READ: begin
        state_nxt = dlle_pkg::B_DATA;
      end
      dlle_pkg::B_DATA: begin
        if (slot_free) begin
          state_nxt = data_last ? dlle_pkg::B_IDLE : dlle_pkg::B_READ;
        end
      end
      default: begin
        state_nxt = dlle_pkg::B_IDLE;
      end
    endcase
  end

  // Outputs of each state.
  always_comb begin
    pop          = 1'b0;
    rd_en        = 1'b0;
    load         = 1'b0;
    idx_nxt      = idx_r;
    out_item_nxt = out_item_r;
    case (state_r)
      dlle_pkg::B_IDLE: begin
        pop     = cmd_avail;
        idx_nxt = '0;
      end
      dlle_pkg::B_LEN: begin
        load                     = slot_free;
        out_item_nxt.out_byte    = 8'(cmd_r.count);
        out_item_nxt.is_length   = 1'b1;
        out_item_nxt.last_of_run = cmd_r.count == '0;
        out_item_nxt.name_end    = cmd_r.name_end && (cmd_r.count == '0);
        out_item_nxt.overflow    = cmd_r.ovf;
      end
      dlle_pkg::B_READ: begin
        rd_en = 1'b1;
      end
      dlle_pkg::B_DATA: begin
        load                     = slot_free;
        out_item_nxt.out_byte    = rd_data;
        out_item_nxt.is_length   = 1'b0;
        out_item_nxt.last_of_run = data_last;
        out_item_nxt.name_end    = cmd_r.name_end && data_last;
        out_item_nxt.overflow    = cmd_r.ovf;
        if (slot_free) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    if (!load) begin
      out_item_nxt = out_item_r;
    end
  end

  assign rd_addr = AW'(idx_r) + (cmd_r.bank ? AW'(MAX_LABEL) : AW'(0));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= cmd_in;
    end
    idx_r      <= idx_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlle_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cmd_avail && state_r == dlle_pkg::B_IDLE)
    else $error("command popped without one waiting");

  a_read_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dlle_pkg::B_READ |=> state_r == dlle_pkg::B_DATA)
    else $error("store read not followed by data state");

  a_idx_in_label: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dlle_pkg::B_DATA |-> idx_r < cmd_r.count)
    else $error("data index beyond label length");

  a_last_ends_label: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_item_nxt.last_of_run |=> state_r == dlle_pkg::B_IDLE)
    else $error("label continued after its last byte");
`endif

endmodule
